### rtl/primap_pkg.sv
// Shared types and constants for the pooled row index mapper.
package primap_pkg;

  localparam int unsigned RowBitsDef   = 32;
  localparam int unsigned WidthBitsDef = 16;
  localparam int unsigned CfgIdxBits   = 2;
  localparam int unsigned CfgDataBits  = 32;
  localparam int unsigned OutBits      = 32;

  typedef enum logic [1:0] {
    FUNC_SRC  = 2'd0,
    FUNC_PAR  = 2'd1,
    FUNC_BASE = 2'd2,
    FUNC_NONE = 2'd3
  } func_e;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_VIDEO_START = 2'd0,
    REG_GRID_WIDTH  = 2'd1,
    REG_REDUCED_END = 2'd2,
    REG_UNUSED      = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic  valid;
    func_e func;
    logic  pass;
  } ctl_t;

endpackage

### rtl/primap_div_cell.sv
// One restoring division cell: resolves a single quotient bit per word.
module primap_div_cell #(
  parameter int unsigned RowBits   = primap_pkg::RowBitsDef,
  parameter int unsigned WidthBits = primap_pkg::WidthBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  primap_pkg::ctl_t     ctl_i,
  input  logic [RowBits-1:0]   num_i,
  input  logic [WidthBits-1:0] rem_i,
  input  logic [WidthBits-1:0] div_i,
  input  logic [RowBits-1:0]   row_i,
  output primap_pkg::ctl_t     ctl_o,
  output logic [RowBits-1:0]   num_o,
  output logic [WidthBits-1:0] rem_o,
  output logic [WidthBits-1:0] div_o,
  output logic [RowBits-1:0]   row_o
);
  import primap_pkg::*;

  logic [WidthBits:0]   trial;
  logic [WidthBits:0]   diff;
  logic                 ge;
  ctl_t                 ctl_q;
  logic [RowBits-1:0]   num_d, num_q, row_q;
  logic [WidthBits-1:0] rem_d, rem_q, div_q;

  always_comb begin
    trial = {rem_i, num_i[RowBits-1]};
    ge    = trial >= {1'b0, div_i};
    diff  = trial - {1'b0, div_i};
    rem_d = ge ? diff[WidthBits-1:0] : trial[WidthBits-1:0];
    num_d = {num_i[RowBits-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    div_q <= div_i;
    row_q <= row_i;
  end

  assign ctl_o = ctl_q;
  assign num_o = num_q;
  assign rem_o = rem_q;
  assign div_o = div_q;
  assign row_o = row_q;

endmodule

### rtl/primap_post.sv
// Multiply and finishing stages: turns quotient and remainder into row words.
module primap_post #(
  parameter int unsigned RowBits   = primap_pkg::RowBitsDef,
  parameter int unsigned WidthBits = primap_pkg::WidthBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [RowBits-1:0]          video_start_i,
  input  logic [WidthBits-1:0]        grid_width_i,
  input  logic [RowBits-1:0]          reduced_end_i,
  input  primap_pkg::ctl_t            ctl_i,
  input  logic [RowBits-1:0]          quot_i,
  input  logic [WidthBits-1:0]        rem_i,
  input  logic [RowBits-1:0]          row_i,
  output logic                        done_o,
  output logic [primap_pkg::OutBits-1:0] first_source_o,
  output logic [primap_pkg::OutBits-1:0] second_source_o,
  output logic [primap_pkg::OutBits-1:0] parent_row_o,
  output logic [primap_pkg::OutBits-1:0] baseline_slot_o,
  output logic                        baseline_found_o
);
  import primap_pkg::*;

  logic [WidthBits:0]         red_w;
  logic [WidthBits-1:0]       red, mul_b;
  logic [RowBits+WidthBits-1:0] prod_full;
  ctl_t                       ctl_q;
  logic [RowBits-1:0]         prod_q, quot_q, row_q;
  logic [WidthBits-1:0]       rem_q;

  logic [RowBits-1:0]         src, sec, par, local_r, slot;
  logic                       two, found;
  logic [OutBits-1:0]         first_d, second_d, parent_d, slot_d;
  logic                       found_d;
  logic                       done_q, found_q;
  logic [OutBits-1:0]         first_q, second_q, parent_q, slot_q;

  always_comb begin
    red_w     = ({1'b0, grid_width_i} + 1'b1) >> 1;
    red       = red_w[WidthBits-1:0];
    mul_b     = (ctl_i.func == FUNC_PAR) ? red : grid_width_i;
    prod_full = quot_i * mul_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q  <= '0;
      done_q <= 1'b0;
    end else begin
      ctl_q  <= ctl_i;
      done_q <= ctl_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_full[RowBits-1:0];
    quot_q   <= quot_i;
    rem_q    <= rem_i;
    row_q    <= row_i;
    first_q  <= first_d;
    second_q <= second_d;
    parent_q <= parent_d;
    slot_q   <= slot_d;
    found_q  <= found_d;
  end

  always_comb begin
    src     = video_start_i + prod_q + {rem_q, 1'b0};
    two     = {rem_q, 1'b1} < {1'b0, grid_width_i};
    sec     = src + {{(RowBits-1){1'b0}}, two};
    par     = video_start_i + prod_q + {1'b0, rem_q[WidthBits-1:1]};
    local_r = row_q - video_start_i;
    found   = !ctl_q.pass && (row_q < reduced_end_i) && two;
    slot    = !found ? '1 : (grid_width_i[0] ? local_r - quot_q : local_r);
    first_d  = '0;
    second_d = '0;
    parent_d = '0;
    slot_d   = '0;
    found_d  = 1'b0;
    case (ctl_q.func)
      FUNC_SRC: begin
        first_d  = OutBits'(ctl_q.pass ? row_q : src);
        second_d = OutBits'(ctl_q.pass ? row_q : sec);
      end
      FUNC_PAR: begin
        parent_d = OutBits'(ctl_q.pass ? row_q : par);
      end
      FUNC_BASE: begin
        slot_d  = OutBits'(slot);
        found_d = found;
      end
      default: begin
      end
    endcase
  end

  assign done_o           = done_q;
  assign first_source_o   = first_q;
  assign second_source_o  = second_q;
  assign parent_row_o     = parent_q;
  assign baseline_slot_o  = slot_q;
  assign baseline_found_o = found_q;

endmodule

### rtl/pooled_row_index_mapper.sv
// Top level of the pooled row index mapper: registers, division chain, finish.
//
// Use: write video_start, grid_width and reduced_end through the plain write
// port (cfg_we_i, cfg_idx_i, cfg_wdata_i) while no query is in flight. A
// query word (func_i, row_index_i) is taken at any clock edge with start_i
// high and busy_o low; busy_o is never raised, so one word per cycle enters.
// Each query yields exactly one result word, shown for one cycle with done_o
// high; the receiver cannot stall, so results leave in order one per cycle.
// The quotient and remainder of the local row by the reduced or full grid
// width come from a chain of ROW_BITS division cells, one quotient bit per
// cell; a multiply stage and an output stage follow.
// Throughput is one word per cycle.
// Reset clears the registers to zero (mapping disabled) and drops every word
// in flight; no result is shown until new queries arrive.
module pooled_row_index_mapper #(
  parameter int unsigned ROW_BITS   = primap_pkg::RowBitsDef,
  parameter int unsigned WIDTH_BITS = primap_pkg::WidthBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [primap_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [primap_pkg::CfgDataBits-1:0] cfg_wdata_i,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [1:0]                        func_i,
  input  logic [ROW_BITS-1:0]               row_index_i,
  output logic                              done_o,
  output logic [primap_pkg::OutBits-1:0]     first_source_o,
  output logic [primap_pkg::OutBits-1:0]     second_source_o,
  output logic [primap_pkg::OutBits-1:0]     parent_row_o,
  output logic [primap_pkg::OutBits-1:0]     baseline_slot_o,
  output logic                              baseline_found_o
);
  import primap_pkg::*;

  logic [ROW_BITS-1:0]   video_start_q, reduced_end_q;
  logic [WIDTH_BITS-1:0] grid_width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      video_start_q <= '0;
      grid_width_q  <= '0;
      reduced_end_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_VIDEO_START: video_start_q <= cfg_wdata_i[ROW_BITS-1:0];
        REG_GRID_WIDTH:  grid_width_q  <= cfg_wdata_i[WIDTH_BITS-1:0];
        REG_REDUCED_END: reduced_end_q <= cfg_wdata_i[ROW_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign busy_o = 1'b0;

  ctl_t                  ctl_c [ROW_BITS+1];
  logic [ROW_BITS-1:0]   num_c [ROW_BITS+1];
  logic [WIDTH_BITS-1:0] rem_c [ROW_BITS+1];
  logic [WIDTH_BITS-1:0] div_c [ROW_BITS+1];
  logic [ROW_BITS-1:0]   row_c [ROW_BITS+1];
  logic [WIDTH_BITS:0]   red_w;

  always_comb begin
    red_w          = ({1'b0, grid_width_q} + 1'b1) >> 1;
    ctl_c[0].valid = start_i && !busy_o;
    ctl_c[0].func  = func_e'(func_i);
    ctl_c[0].pass  = (row_index_i < video_start_q) || (grid_width_q == '0);
    num_c[0]       = row_index_i - video_start_q;
    rem_c[0]       = '0;
    div_c[0]       = (func_e'(func_i) == FUNC_PAR) ? grid_width_q
                                                  : red_w[WIDTH_BITS-1:0];
    row_c[0]       = row_index_i;
  end

  for (genvar i = 0; i < ROW_BITS; i++) begin : g_cell
    primap_div_cell #(
      .RowBits   (ROW_BITS),
      .WidthBits (WIDTH_BITS)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl_c[i]),
      .num_i  (num_c[i]),
      .rem_i  (rem_c[i]),
      .div_i  (div_c[i]),
      .row_i  (row_c[i]),
      .ctl_o  (ctl_c[i+1]),
      .num_o  (num_c[i+1]),
      .rem_o  (rem_c[i+1]),
      .div_o  (div_c[i+1]),
      .row_o  (row_c[i+1])
    );
  end

  primap_post #(
    .RowBits   (ROW_BITS),
    .WidthBits (WIDTH_BITS)
  ) u_post (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .video_start_i    (video_start_q),
    .grid_width_i     (grid_width_q),
    .reduced_end_i    (reduced_end_q),
    .ctl_i            (ctl_c[ROW_BITS]),
    .quot_i           (num_c[ROW_BITS]),
    .rem_i            (rem_c[ROW_BITS]),
    .row_i            (row_c[ROW_BITS]),
    .done_o           (done_o),
    .first_source_o   (first_source_o),
    .second_source_o  (second_source_o),
    .parent_row_o     (parent_row_o),
    .baseline_slot_o  (baseline_slot_o),
    .baseline_found_o (baseline_found_o)
  );

endmodule
